FILE: hdl/allocation_tracking_table_assert.svh
// Assertion macros used by the allocation tracking table datapath.
// Each macro expects a clock named clock and a synchronous reset named reset in scope.
`ifndef ALLOCATION_TRACKING_TABLE_ASSERT_SVH
`define ALLOCATION_TRACKING_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocation tracking table: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ATT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocation tracking table: assertion failed");

`endif

FILE: hdl/att_pkg.sv
// Shared types, widths and codes for the allocation tracking table.
// No dependencies; the datapath, controller, top level and testbench import this package.
package att_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 64;
   localparam int SIZE_W      = 32;
   localparam int SUM_W       = 64;
   localparam int TALLY_W     = 32;
   localparam int LIVE_W      = 11;

   localparam logic OP_RECORD = 1'b0;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_MISSING = 2'd2;

   typedef struct packed {
      logic              opcode;
      logic [KEY_W-1:0]  block_key;
      logic [SIZE_W-1:0] block_bytes;
   } att_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [LIVE_W-1:0]  live_entries;
      logic [SUM_W-1:0]   total_bytes;
      logic [SUM_W-1:0]   current_bytes;
      logic [SUM_W-1:0]   peak_bytes;
      logic [TALLY_W-1:0] records_made;
   } att_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic do_record;
      logic scan_en;
      logic take_hit;
      logic set_missing;
      logic move_rd;
      logic move_wr;
      logic load_rsp;
   } att_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_record;
      logic empty;
      logic hit;
      logic miss;
   } att_sts_type;

endpackage

FILE: hdl/att_dpath.sv
// Datapath of the allocation tracking table: key and size memories, scan pipeline,
// statistics registers and the result register. Depends on att_pkg and the assert header.
`include "allocation_tracking_table_assert.svh"

module att_dpath (
   input  logic                clock,
   input  logic                reset,
   input  att_pkg::att_cmd_type cmd,
   output att_pkg::att_sts_type sts,
   input  att_pkg::att_req_type req_data,
   output att_pkg::att_rsp_type rsp_data
);
   import att_pkg::*;

   logic [KEY_W-1:0]   key_mem  [TABLE_DEPTH];
   logic [SIZE_W-1:0]  size_mem [TABLE_DEPTH];

   att_req_type        req_ff;
   att_rsp_type        rsp_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic [SUM_W-1:0]   current_ff, current_in;
   logic [SUM_W-1:0]   peak_ff, peak_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [1:0]         stat_ff, stat_in;
   logic [CNT_W-1:0]   scan_ff;
   logic [CNT_W-1:0]   rd_idx_ff;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [SIZE_W-1:0]  rd_size_ff;

   logic               full;
   logic               issue;
   logic               match;
   logic               at_last;
   logic [IDX_W-1:0]   last_idx;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [KEY_W-1:0]   wr_key;
   logic [SIZE_W-1:0]  wr_size;
   logic [SUM_W-1:0]   cur_sum;

   assign full     = (count_ff == CNT_W'(TABLE_DEPTH));
   assign issue    = cmd.scan_en && (scan_ff < count_ff);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign match    = rd_vld_ff && (rd_key_ff == req_ff.block_key);
   assign at_last  = ((rd_idx_ff + CNT_W'(1)) == count_ff);
   assign cur_sum  = current_ff + SUM_W'(req_ff.block_bytes);

   assign rd_en   = issue || cmd.move_rd;
   assign rd_addr = cmd.move_rd ? last_idx : scan_ff[IDX_W-1:0];
   assign wr_en   = (cmd.do_record && !full) || cmd.move_wr;
   assign wr_addr = cmd.move_wr ? hit_idx_ff : count_ff[IDX_W-1:0];
   assign wr_key  = cmd.move_wr ? rd_key_ff : req_ff.block_key;
   assign wr_size = cmd.move_wr ? rd_size_ff : req_ff.block_bytes;

   assign sts.is_record = (req_ff.opcode == OP_RECORD);
   assign sts.empty     = (count_ff == '0);
   assign sts.hit       = match;
   assign sts.miss      = rd_vld_ff && !match && at_last;

   assign rsp_data = rsp_ff;

   // Table memories: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         size_mem[wr_addr] <= wr_size;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_size_ff <= size_mem[rd_addr];
      end
   end

   always_comb begin
      count_in   = count_ff;
      total_in   = total_ff;
      current_in = current_ff;
      peak_in    = peak_ff;
      tally_in   = tally_ff;
      stat_in    = stat_ff;
      if (cmd.do_record) begin
         if (full) begin
            stat_in = STAT_FULL;
         end else begin
            stat_in    = STAT_OK;
            count_in   = count_ff + CNT_W'(1);
            total_in   = total_ff + SUM_W'(req_ff.block_bytes);
            current_in = cur_sum;
            tally_in   = tally_ff + TALLY_W'(1);
            if (cur_sum > peak_ff) begin
               peak_in = cur_sum;
            end
         end
      end
      if (cmd.take_hit) begin
         stat_in    = STAT_OK;
         current_in = current_ff - SUM_W'(rd_size_ff);
      end
      if (cmd.set_missing) begin
         stat_in = STAT_MISSING;
      end
      if (cmd.move_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         total_ff   <= '0;
         current_ff <= '0;
         peak_ff    <= '0;
         tally_ff   <= '0;
         scan_ff    <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         total_ff   <= total_in;
         current_ff <= current_in;
         peak_ff    <= peak_in;
         tally_ff   <= tally_in;
         rd_vld_ff  <= issue;
         if (cmd.load_req) begin
            scan_ff <= '0;
         end else if (issue) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (issue) begin
         rd_idx_ff <= scan_ff;
      end
      if (cmd.take_hit) begin
         hit_idx_ff <= rd_idx_ff[IDX_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_ff.status        <= stat_ff;
         rsp_ff.live_entries  <= LIVE_W'(count_ff);
         rsp_ff.total_bytes   <= total_ff;
         rsp_ff.current_bytes <= current_ff;
         rsp_ff.peak_bytes    <= peak_ff;
         rsp_ff.records_made  <= tally_ff;
      end
   end

   `ATT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `ATT_ASSERT_NEXT(a_full_holds, cmd.do_record && full, $stable(count_ff) && $stable(current_ff))
   `ATT_ASSERT_NEXT(a_move_shrinks, cmd.move_wr, count_ff == $past(count_ff) - CNT_W'(1))
   `ATT_ASSERT_NEXT(a_peak_covers, cmd.do_record, peak_ff >= current_ff)

endmodule

FILE: hdl/att_ctrl.sv
// Controller of the allocation tracking table: sequences record, scan and move steps.
// Depends on att_pkg for the command and status structs.
module att_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  att_pkg::att_sts_type sts,
   output att_pkg::att_cmd_type cmd
);
   import att_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_MOVE_RD,
      S_MOVE_WR,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_ready_ff && req_valid) begin
               cmd.load_req = 1'b1;
               req_ready_in = 1'b0;
               state_in     = S_DISPATCH;
            end else begin
               req_ready_in = 1'b1;
            end
         end
         S_DISPATCH: begin
            if (sts.is_record) begin
               cmd.do_record = 1'b1;
               state_in      = S_DONE;
            end else if (sts.empty) begin
               cmd.set_missing = 1'b1;
               state_in        = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = S_MOVE_RD;
            end else if (sts.miss) begin
               cmd.set_missing = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.scan_en = 1'b1;
            end
         end
         S_MOVE_RD: begin
            cmd.move_rd = 1'b1;
            state_in    = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            cmd.move_wr = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               req_ready_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/allocation_tracking_table.sv
// Top level of the allocation tracking table: joins the controller and the datapath.
// Depends on att_pkg, att_ctrl and att_dpath.
//
// Usage: the request channel (req_valid, req_ready, req_data) carries one operation per
// transfer: a record appends a key and size, a release removes the first entry holding
// the key and fills its slot with the last entry. The response channel (rsp_valid,
// rsp_ready, rsp_data) returns exactly one result per request, with the status and all
// the byte and count statistics as they stand after the operation.
// Sequence: a record, and a release on an empty table, goes from dispatch straight to
// the result register. A release scans the entries from index 0 until it hits or passes
// the last entry, reading one entry per cycle through the single read port of the table
// memory; a hit then moves the last entry into the freed slot. The block works on one
// request at a time and takes no new request until the result has been loaded.
// Reset clears the entry count and every statistic at once; the table memory is not
// cleared, since only entries below the count are ever read.
// A finished result waits in the output register while the receiver stalls; the next
// request is taken meanwhile, and its result is held back until the previous transfer.
module allocation_tracking_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  att_pkg::att_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output att_pkg::att_rsp_type rsp_data
);
   import att_pkg::*;

   // Command and status buses between the sequencer and the datapath.
   att_cmd_type cmd;
   att_sts_type sts;

   att_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   att_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

FILE: test/tb_allocation_tracking_table.sv
// Self-checking testbench for allocation_tracking_table: random and directed record/release
// traffic with idling on both channels, checked against an in-bench model of the table.
// Depends on att_pkg and the allocation_tracking_table RTL; reads and writes no files.
`timescale 1ns / 1ps

module tb_allocation_tracking_table;
   import att_pkg::*;

   // The package names only the record code, so the release code is local to the bench.
   localparam logic OP_RELEASE     = 1'b1;
   localparam int   WATCHDOG_LIMIT = 5000;
   localparam int   TAIL_CYCLES    = 1100;
   localparam int   RANDOM_OPS     = 450;

   // One pending operation together with the sender's behaviour around it.
   typedef struct {
      att_req_type op;
      int          gap;
      bit          hold;
   } alloc_op_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   att_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   att_rsp_type rsp_data;

   allocation_tracking_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Model of the table. It is advanced once per request transfer, in transfer order, so
   // its state always matches what the block should hold after the last accepted request.
   // ---------------------------------------------------------------------------------------
   logic [KEY_W-1:0]   live_key  [TABLE_DEPTH];
   logic [SIZE_W-1:0]  live_size [TABLE_DEPTH];
   int                 live_count    = 0;
   logic [SUM_W-1:0]   bytes_total   = '0;
   logic [SUM_W-1:0]   bytes_current = '0;
   logic [SUM_W-1:0]   bytes_peak    = '0;
   logic [TALLY_W-1:0] alloc_tally   = '0;

   function automatic att_rsp_type track_op(att_req_type op);
      att_rsp_type stats;
      logic [1:0]  st;
      int          hit_at;
      int          i;
      st = STAT_OK;
      if (op.opcode == OP_RECORD) begin
         if (live_count >= TABLE_DEPTH) begin
            // A full table takes nothing and leaves every statistic alone.
            st = STAT_FULL;
         end else begin
            live_key[live_count]  = op.block_key;
            live_size[live_count] = op.block_bytes;
            live_count++;
            bytes_total   = bytes_total + SUM_W'(op.block_bytes);
            bytes_current = bytes_current + SUM_W'(op.block_bytes);
            alloc_tally   = alloc_tally + 1'b1;
            if (bytes_current > bytes_peak) begin
               bytes_peak = bytes_current;
            end
         end
      end else begin
         // Only the lowest-indexed match is removed; the last entry fills its slot.
         hit_at = -1;
         for (i = 0; i < live_count; i++) begin
            if (hit_at < 0 && live_key[i] == op.block_key) begin
               hit_at = i;
            end
         end
         if (hit_at < 0) begin
            st = STAT_MISSING;
         end else begin
            bytes_current     = bytes_current - SUM_W'(live_size[hit_at]);
            live_key[hit_at]  = live_key[live_count-1];
            live_size[hit_at] = live_size[live_count-1];
            live_count--;
         end
      end
      stats.status        = st;
      stats.live_entries  = LIVE_W'(live_count);
      stats.total_bytes   = bytes_total;
      stats.current_bytes = bytes_current;
      stats.peak_bytes    = bytes_peak;
      stats.records_made  = alloc_tally;
      return stats;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus. The whole sequence is built at time zero. A shadow list of live keys is kept
   // while building, so that most releases can name a key that is really in the table.
   // ---------------------------------------------------------------------------------------
   alloc_op_type     op_queue[$];
   logic [KEY_W-1:0] shadow_keys[$];
   int               sender_idle_max = 11;
   int               total_ops       = 0;

   function automatic int pick_idle_max();
      case ($urandom_range(0, 2))
         0: begin
            return 0;
         end
         1: begin
            return 3;
         end
         default: begin
            return 11;
         end
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] draw_bytes();
      case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2, 3: begin
            return SIZE_W'($urandom_range(1, 4096));
         end
         default: begin
            return SIZE_W'($urandom);
         end
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] draw_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] pick_live_key();
      return shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
   endfunction

   function automatic void push_op(logic opcode, logic [KEY_W-1:0] key,
                                   logic [SIZE_W-1:0] bytes, bit hold);
      alloc_op_type item;
      int           found;
      int           i;
      item.op.opcode      = opcode;
      item.op.block_key   = key;
      item.op.block_bytes = bytes;
      item.gap            = $urandom_range(0, sender_idle_max);
      item.hold           = hold;
      op_queue.push_back(item);
      if (opcode == OP_RECORD) begin
         if (shadow_keys.size() < TABLE_DEPTH) begin
            shadow_keys.push_back(key);
         end
      end else begin
         found = -1;
         for (i = 0; i < shadow_keys.size(); i++) begin
            if (found < 0 && shadow_keys[i] == key) begin
               found = i;
            end
         end
         if (found >= 0) begin
            shadow_keys.delete(found);
         end
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Expected results are stored by sequence number. The driver writes entry n in the step
   // of the n-th request transfer and only then advances its counter by a nonblocking
   // assignment, so the monitor never sees an entry before it has been written.
   // ---------------------------------------------------------------------------------------
   att_rsp_type expected_stats[int];
   int          req_count_q     = 0;
   int          rsp_count_q     = 0;
   int          mismatch_count  = 0;
   logic        timed_out       = 1'b0;

   // Driver. Each operation waits out its own gap once the channel is free; an operation
   // marked hold is also kept back until every result issued so far has come back.
   int          send_left  = 0;
   bit          send_armed = 1'b0;

   always @(posedge clock) begin
      bit          xfer;
      bit          valid_n;
      att_req_type data_n;
      xfer    = req_valid && req_ready;
      valid_n = req_valid;
      data_n  = req_data;
      if (reset) begin
         req_valid  <= 1'b0;
         send_armed = 1'b0;
      end else begin
         if (xfer) begin
            expected_stats[req_count_q] = track_op(req_data);
            req_count_q <= req_count_q + 1;
         end
         if (!req_valid || xfer) begin
            valid_n = 1'b0;
            if (op_queue.size() != 0) begin
               if (!send_armed) begin
                  send_left  = op_queue[0].gap;
                  send_armed = 1'b1;
               end
               if (send_left != 0) begin
                  send_left--;
               end else if (!op_queue[0].hold || (!xfer && req_count_q == rsp_count_q)) begin
                  valid_n    = 1'b1;
                  data_n     = op_queue[0].op;
                  send_armed = 1'b0;
                  void'(op_queue.pop_front());
               end
            end
            req_valid <= valid_n;
            if (valid_n) begin
               req_data <= data_n;
            end
         end
      end
   end

   // Field comparison shared by all six result fields.
   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got,
                                       int seq);
      if (want !== got) begin
         if (mismatch_count < 10) begin
            $display("result %0d: %s expected 0x%0h, got 0x%0h", seq, field, want, got);
         end
         mismatch_count++;
      end
   endfunction

   // Monitor. After every result transfer the receiver draws a stall; the stall bound is
   // redrawn every few dozen results, which gives stretches with no stalling at all.
   int          stall_left   = 0;
   int          stall_max    = 11;
   int          results_seen = 0;

   always @(posedge clock) begin
      att_rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_count_q == req_count_q) begin
               if (mismatch_count < 10) begin
                  $display("result with no request outstanding: 0x%0h", rsp_data);
               end
               mismatch_count++;
            end else begin
               want = expected_stats[rsp_count_q];
               check_field("status", 64'(want.status), 64'(rsp_data.status), rsp_count_q);
               check_field("live_entries", 64'(want.live_entries),
                           64'(rsp_data.live_entries), rsp_count_q);
               check_field("total_bytes", want.total_bytes, rsp_data.total_bytes,
                           rsp_count_q);
               check_field("current_bytes", want.current_bytes, rsp_data.current_bytes,
                           rsp_count_q);
               check_field("peak_bytes", want.peak_bytes, rsp_data.peak_bytes, rsp_count_q);
               check_field("records_made", 64'(want.records_made),
                           64'(rsp_data.records_made), rsp_count_q);
               expected_stats.delete(rsp_count_q);
               rsp_count_q <= rsp_count_q + 1;
            end
            results_seen++;
            if (results_seen % 48 == 0) begin
               stall_max = pick_idle_max();
            end
            stall_left = $urandom_range(0, stall_max);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   // Watchdog: the longest legal quiet spell is a missed release on a full table plus the
   // idling on both sides; the limit allows several times that.
   int          quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         timed_out <= 1'b1;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int               n;
      int               live;
      int               pick;
      bit               do_release;
      logic [KEY_W-1:0] key;

      // Directed part: release on an empty table, extreme keys and sizes, duplicate keys
      // where only the lowest-indexed copy may go, misses on a non-empty table, and
      // releases of the first and of the last entry.
      push_op(OP_RELEASE, '0, '1, 1'b0);
      push_op(OP_RECORD, '0, '0, 1'b0);
      push_op(OP_RECORD, '1, '1, 1'b0);
      push_op(OP_RECORD, 64'h0123_4567_89AB_CDEF, 32'd1, 1'b0);
      push_op(OP_RECORD, '1, 32'h8000_0000, 1'b0);
      push_op(OP_RELEASE, '1, '0, 1'b0);
      push_op(OP_RELEASE, '1, '0, 1'b0);
      push_op(OP_RELEASE, '1, '0, 1'b0);
      push_op(OP_RELEASE, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0);
      push_op(OP_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0);
      push_op(OP_RECORD, 64'h8000_0000_0000_0001, 32'hFFFF_FFFE, 1'b0);
      push_op(OP_RELEASE, '0, '0, 1'b0);
      push_op(OP_RELEASE, 64'h8000_0000_0000_0001, '0, 1'b0);
      push_op(OP_RELEASE, 64'h0123_4567_89AB_CDEF, '0, 1'b0);
      push_op(OP_RELEASE, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0);
      push_op(OP_RELEASE, '0, '0, 1'b0);

      // Random part: a small table churned by records and releases, mostly of live keys,
      // with occasional duplicates, extreme keys and misses. The first operation, and every
      // hundred and fiftieth after it, waits until the block has drained.
      for (n = 0; n < RANDOM_OPS; n++) begin
         if (n % 40 == 0) begin
            sender_idle_max = pick_idle_max();
         end
         live = shadow_keys.size();
         if (live == 0) begin
            do_release = ($urandom_range(0, 9) == 0);
         end else if (live > 40) begin
            do_release = ($urandom_range(0, 3) != 0);
         end else begin
            do_release = ($urandom_range(0, 9) < 4);
         end
         if (do_release) begin
            if (live != 0 && $urandom_range(0, 4) != 0) begin
               key = pick_live_key();
            end else begin
               key = draw_key();
            end
            push_op(OP_RELEASE, key, draw_bytes(), n % 150 == 0);
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 2 && live != 0) begin
               key = pick_live_key();
            end else if (pick == 2) begin
               key = $urandom_range(0, 1) ? '1 : '0;
            end else begin
               key = draw_key();
            end
            push_op(OP_RECORD, key, draw_bytes(), n % 150 == 0);
         end
      end

      // Fill the table to its depth, then try records against the full table, free a few
      // entries (one release misses and so scans the whole table) and fill it up again.
      sender_idle_max = 2;
      push_op(OP_RECORD, draw_key(), draw_bytes(), 1'b1);
      while (shadow_keys.size() < TABLE_DEPTH) begin
         push_op(OP_RECORD, draw_key(), draw_bytes(), 1'b0);
      end
      sender_idle_max = 11;
      for (n = 0; n < 3; n++) begin
         push_op(OP_RECORD, draw_key(), '1, 1'b0);
      end
      for (n = 0; n < 6; n++) begin
         if (n == 2) begin
            push_op(OP_RELEASE, draw_key(), draw_bytes(), 1'b0);
         end else begin
            push_op(OP_RELEASE, pick_live_key(), draw_bytes(), 1'b0);
         end
      end
      while (shadow_keys.size() < TABLE_DEPTH) begin
         push_op(OP_RECORD, draw_key(), draw_bytes(), 1'b0);
      end
      push_op(OP_RECORD, '1, '1, 1'b0);
      push_op(OP_RELEASE, pick_live_key(), '0, 1'b0);

      total_ops = op_queue.size();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      fork
         begin
            wait (req_count_q == total_ops);
            wait (rsp_count_q == req_count_q);
            repeat (TAIL_CYCLES) @(posedge clock);
         end
         wait (timed_out);
      join_any

      if (timed_out) begin
         $display("SCOREBOARD MISMATCH");
      end else if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/att_pkg.sv
hdl/att_dpath.sv
hdl/att_ctrl.sv
hdl/allocation_tracking_table.sv
test/tb_allocation_tracking_table.sv
